>>> hw/rtl/bfsp_pkg.sv
// Shared types and character codes for the bracket frame sensor parser.
// Used by the stream interface instances and the top level; depends on nothing.

package bfsp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_HUNT   = 7'b000_0001,
    PH_KIND   = 7'b000_0010,
    PH_SPACE  = 7'b000_0100,
    PH_SIGN   = 7'b000_1000,
    PH_DIGITS = 7'b001_0000,
    PH_SKIP   = 7'b010_0000,
    PH_DROP   = 7'b100_0000
  } phase_t;

  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_KIND_US = 8'h75;
  localparam logic [7:0] CH_KIND_IR = 8'h69;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic KIND_US = 1'b0;
  localparam logic KIND_IR = 1'b1;

  localparam logic [3:0] FIELD_COUNT_MAX = 4'd15;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               frame_kind;
    logic [3:0]         field_count;
    logic signed [15:0] us_first;
    logic signed [15:0] us_second;
    logic signed [15:0] ir_first;
    logic signed [15:0] ir_second;
    logic signed [15:0] ir_third;
  } out_item_t;

endpackage

>>> hw/rtl/bfsp_stream_if.sv
// Valid/ready stream channel with a source and a sink side.
// The payload type is chosen per instance; no package dependency.

interface bfsp_stream_if #(
  parameter type payload_t = logic [7:0]
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> hw/rtl/bracket_frame_sensor_parser.sv
// Bracket frame sensor parser: top level.
// Depends on bfsp_pkg and the bfsp_stream_if channel interface.
//
// Usage:
//   rx carries one received ASCII byte per transaction (bfsp_pkg::in_item_t).
//   tx carries one result per completed "[u...]" or "[i...]" frame
//   (bfsp_pkg::out_item_t): the frame kind, its field count and every
//   latched ultrasonic and infrared value after the frame was applied.
//   Frames of any other kind, empty frames and bytes outside frames give
//   no result.
// Timing:
//   Each byte is parsed in the cycle it is accepted; a closing bracket
//   registers its result into the output register, or into the skid register
//   while tx stalls. One byte per cycle is taken while tx keeps up.
//   Results go through an output register backed by one skid register, so
//   a stalled tx does not stop rx until both hold a result; rx.ready then
//   stays low until the output register is drained. rx.ready comes from a
//   register only.
// Reset:
//   rst clears the parser to the hunt for an opening bracket, zeroes all
//   latched values and empties the output registers.

module bracket_frame_sensor_parser
  import bfsp_pkg::*;
#(
  parameter int VALUE_WIDTH = 16,
  parameter int US_SLOTS    = 2,
  parameter int IR_SLOTS    = 3
) (
  input  logic             clk,
  input  logic             rst,
  bfsp_stream_if.sink      rx,
  bfsp_stream_if.source    tx
);

  localparam int STAGE_SLOTS = (US_SLOTS > IR_SLOTS) ? US_SLOTS : IR_SLOTS;
  localparam int SIDX_W      = (STAGE_SLOTS > 1) ? $clog2(STAGE_SLOTS) : 1;
  localparam int AW          = VALUE_WIDTH + 4;
  localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] POS_LIMIT = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  phase_t                        phase, phase_next;
  logic                          kind, kind_next;
  logic [3:0]                    field_index, field_index_next;
  logic [VALUE_WIDTH-1:0]        acc, acc_next;
  logic                          neg, neg_next;
  logic signed [VALUE_WIDTH-1:0] staged [STAGE_SLOTS];
  logic signed [VALUE_WIDTH-1:0] staged_next [STAGE_SLOTS];
  logic signed [VALUE_WIDTH-1:0] us_vals [US_SLOTS];
  logic signed [VALUE_WIDTH-1:0] us_vals_next [US_SLOTS];
  logic signed [VALUE_WIDTH-1:0] ir_vals [IR_SLOTS];
  logic signed [VALUE_WIDTH-1:0] ir_vals_next [IR_SLOTS];

  out_item_t out_reg, skid_reg, result;
  logic      out_valid, skid_valid;
  logic      emit;

  logic                          fire, pop;
  logic [7:0]                    c;
  logic                          c_space, c_digit;
  logic [AW-1:0]                 acc_wide;
  logic [VALUE_WIDTH-1:0]        acc_digit;
  logic signed [VALUE_WIDTH-1:0] field_val;
  logic [3:0]                    count_val;

  assign c        = rx.data.rx_byte;
  assign fire     = rx.valid & rx.ready;
  assign pop      = out_valid & tx.ready;
  assign rx.ready = ~skid_valid;
  assign tx.valid = out_valid;
  assign tx.data  = out_reg;

  assign c_space = (c == CH_BLANK) || ((c >= CH_TAB) && (c <= CH_CR));
  assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  // acc * 10 + digit, clamped to the largest magnitude that can still be stored.
  assign acc_wide  = (AW'(acc) << 3) + (AW'(acc) << 1) + AW'(c[3:0]);
  assign acc_digit = (acc_wide > AW'(MAG_LIMIT)) ? MAG_LIMIT : acc_wide[VALUE_WIDTH-1:0];

  // The magnitude never exceeds MAG_LIMIT, so its negation stays in range; at MAG_LIMIT it is the most negative value.
  assign field_val = neg ? $signed(-acc)
                         : $signed((acc == MAG_LIMIT) ? POS_LIMIT : acc);

  assign count_val = (field_index == FIELD_COUNT_MAX) ? FIELD_COUNT_MAX
                                                      : field_index + 4'd1;

  always_comb begin
    phase_next       = phase;
    kind_next        = kind;
    field_index_next = field_index;
    acc_next         = acc;
    neg_next         = neg;
    staged_next      = staged;
    us_vals_next     = us_vals;
    ir_vals_next     = ir_vals;
    emit             = 1'b0;

    if (fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (c == CH_LBRACK) phase_next = PH_KIND;
        end
        PH_KIND: begin
          if (c == CH_KIND_US || c == CH_KIND_IR) begin
            kind_next        = (c == CH_KIND_IR) ? KIND_IR : KIND_US;
            field_index_next = '0;
            for (int i = 0; i < STAGE_SLOTS; i++) staged_next[i] = '0;
            acc_next   = '0;
            neg_next   = 1'b0;
            phase_next = PH_SPACE;
          end else if (c == CH_RBRACK) begin
            phase_next = PH_HUNT;
          end else begin
            phase_next = PH_DROP;
          end
        end
        PH_DROP: begin
          if (c == CH_RBRACK) phase_next = PH_HUNT;
        end
        PH_SPACE, PH_SIGN, PH_DIGITS, PH_SKIP: begin
          if (c == CH_COMMA || c == CH_RBRACK) begin
            if (field_index < 4'(STAGE_SLOTS)) begin
              staged_next[field_index[SIDX_W-1:0]] = field_val;
            end
          end
          if (c == CH_COMMA) begin
            if (field_index != FIELD_COUNT_MAX) field_index_next = field_index + 4'd1;
            acc_next   = '0;
            neg_next   = 1'b0;
            phase_next = PH_SPACE;
          end else if (c == CH_RBRACK) begin
            if (kind == KIND_US) begin
              for (int i = 0; i < US_SLOTS; i++) us_vals_next[i] = staged_next[i];
            end else begin
              for (int i = 0; i < IR_SLOTS; i++) ir_vals_next[i] = staged_next[i];
            end
            emit       = 1'b1;
            phase_next = PH_HUNT;
          end else begin
            case (phase)
              PH_SPACE: begin
                if (c_space) begin
                  phase_next = PH_SPACE;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                  neg_next   = (c == CH_MINUS);
                  phase_next = PH_SIGN;
                end else if (c_digit) begin
                  acc_next   = acc_digit;
                  phase_next = PH_DIGITS;
                end else begin
                  phase_next = PH_SKIP;
                end
              end
              PH_SIGN: begin
                if (c_digit) begin
                  acc_next   = acc_digit;
                  phase_next = PH_DIGITS;
                end else begin
                  acc_next   = '0;
                  neg_next   = 1'b0;
                  phase_next = PH_SKIP;
                end
              end
              PH_DIGITS: begin
                if (c_digit) acc_next = acc_digit;
                else phase_next = PH_SKIP;
              end
              default: begin
                phase_next = phase;
              end
            endcase
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Result as seen after this frame was applied; missing slots read as zero.
  always_comb begin
    result             = '0;
    result.frame_kind  = kind;
    result.field_count = count_val;
    result.us_first    = 16'(us_vals_next[0]);
    if (US_SLOTS > 1) result.us_second = 16'(us_vals_next[(US_SLOTS > 1) ? 1 : 0]);
    result.ir_first    = 16'(ir_vals_next[0]);
    if (IR_SLOTS > 1) result.ir_second = 16'(ir_vals_next[(IR_SLOTS > 1) ? 1 : 0]);
    if (IR_SLOTS > 2) result.ir_third  = 16'(ir_vals_next[(IR_SLOTS > 2) ? 2 : 0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      kind        <= KIND_US;
      field_index <= '0;
      acc         <= '0;
      neg         <= 1'b0;
      for (int i = 0; i < STAGE_SLOTS; i++) staged[i] <= '0;
      for (int i = 0; i < US_SLOTS; i++) us_vals[i] <= '0;
      for (int i = 0; i < IR_SLOTS; i++) ir_vals[i] <= '0;
    end else begin
      phase       <= phase_next;
      kind        <= kind_next;
      field_index <= field_index_next;
      acc         <= acc_next;
      neg         <= neg_next;
      staged      <= staged_next;
      us_vals     <= us_vals_next;
      ir_vals     <= ir_vals_next;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= emit;
        end
      end else if (emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) out_reg <= skid_reg;
      else if (emit) out_reg <= result;
    end else if (emit) begin
      skid_reg <= result;
    end
  end

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_close_gives_result : assert property (@(posedge clk) disable iff (rst)
    (fire && c == CH_RBRACK &&
     (phase == PH_SPACE || phase == PH_SIGN || phase == PH_DIGITS || phase == PH_SKIP))
    |=> out_valid)
    else $error("closing bracket of a frame produced no result");

  a_acc_bounded : assert property (@(posedge clk) disable iff (rst)
    acc <= MAG_LIMIT)
    else $error("number accumulator above saturation limit");

  a_skid_refills_out : assert property (@(posedge clk) disable iff (rst)
    (pop && skid_valid) |=> (out_valid && !skid_valid))
    else $error("skid entry lost when the output register was drained");

endmodule

>>> tb/frame_tracker_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the bracket frame sensor parser: tracks the parse of every accepted
// byte, queues the frames it expects and checks each result. Depends on bfsp_pkg.

package frame_tracker_pkg;
  import bfsp_pkg::*;

  localparam int US_SLOTS    = 2;
  localparam int IR_SLOTS    = 3;
  localparam int STAGE_SLOTS = 3;
  localparam int MAG_LIMIT   = 32768;

  class frame_tracker;
    phase_t             phase;
    logic               kind;
    logic [3:0]         field_idx;
    int unsigned        magnitude;
    bit                 negative;
    logic signed [15:0] staged[STAGE_SLOTS];
    logic signed [15:0] us_vals[US_SLOTS];
    logic signed [15:0] ir_vals[IR_SLOTS];
    out_item_t          pending_frames[$];
    int unsigned        frames_checked;
    int unsigned        error_count;

    function new();
      phase = PH_HUNT;
      kind = KIND_US;
      field_idx = '0;
      magnitude = 0;
      negative = 0;
      foreach (staged[k]) staged[k] = '0;
      foreach (us_vals[k]) us_vals[k] = '0;
      foreach (ir_vals[k]) ir_vals[k] = '0;
      frames_checked = 0;
      error_count = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_BLANK || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void open_field();
      magnitude = 0;
      negative = 0;
      phase = PH_SPACE;
    endfunction

    function void push_digit(logic [7:0] c);
      magnitude = magnitude * 10 + int'(c - CH_ZERO);
      if (magnitude > MAG_LIMIT) magnitude = MAG_LIMIT;
      phase = PH_DIGITS;
    endfunction

    // Saturates the field to the 16-bit signed range and stages it if a slot is left.
    function void close_field();
      int value;
      if (negative) begin
        value = -int'((magnitude > MAG_LIMIT) ? MAG_LIMIT : magnitude);
      end else begin
        value = int'((magnitude > MAG_LIMIT - 1) ? MAG_LIMIT - 1 : magnitude);
      end
      if (field_idx < STAGE_SLOTS) staged[field_idx] = 16'(value);
    endfunction

    function void note_rx_byte(logic [7:0] c);
      out_item_t want;
      if (phase == PH_HUNT) begin
        if (c == CH_LBRACK) phase = PH_KIND;
      end else if (phase == PH_KIND) begin
        if (c == CH_KIND_US || c == CH_KIND_IR) begin
          kind = (c == CH_KIND_IR) ? KIND_IR : KIND_US;
          field_idx = '0;
          foreach (staged[k]) staged[k] = '0;
          open_field();
        end else if (c == CH_RBRACK) begin
          phase = PH_HUNT;
        end else begin
          phase = PH_DROP;
        end
      end else if (phase == PH_DROP) begin
        if (c == CH_RBRACK) phase = PH_HUNT;
      end else if (c == CH_COMMA) begin
        close_field();
        if (field_idx < FIELD_COUNT_MAX) field_idx++;
        open_field();
      end else if (c == CH_RBRACK) begin
        close_field();
        if (kind == KIND_US) begin
          for (int k = 0; k < US_SLOTS; k++) us_vals[k] = staged[k];
        end else begin
          for (int k = 0; k < IR_SLOTS; k++) ir_vals[k] = staged[k];
        end
        phase = PH_HUNT;
        want.frame_kind = kind;
        want.field_count = (field_idx < FIELD_COUNT_MAX) ? field_idx + 4'd1 : FIELD_COUNT_MAX;
        want.us_first = us_vals[0];
        want.us_second = us_vals[1];
        want.ir_first = ir_vals[0];
        want.ir_second = ir_vals[1];
        want.ir_third = ir_vals[2];
        pending_frames.insert(pending_frames.size(), want);
      end else begin
        case (phase)
          PH_SPACE: begin
            if (is_blank(c)) begin
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              negative = (c == CH_MINUS);
              phase = PH_SIGN;
            end else if (is_digit(c)) begin
              push_digit(c);
            end else begin
              phase = PH_SKIP;
            end
          end
          PH_SIGN: begin
            if (is_digit(c)) begin
              push_digit(c);
            end else begin
              // A sign with no digit after it makes the field zero.
              magnitude = 0;
              negative = 0;
              phase = PH_SKIP;
            end
          end
          PH_DIGITS: begin
            if (is_digit(c)) push_digit(c);
            else phase = PH_SKIP;
          end
          default: begin
          end
        endcase
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    task check_frame(out_item_t got);
      out_item_t want;
      if (pending_frames.size() == 0) begin
        report_mismatch("result arrived with no frame pending");
      end else begin
        want = pending_frames.pop_front();
        if (got.frame_kind !== want.frame_kind)
          report_mismatch($sformatf("frame %0d frame_kind %0d, expected %0d",
                                    frames_checked, got.frame_kind, want.frame_kind));
        if (got.field_count !== want.field_count)
          report_mismatch($sformatf("frame %0d field_count %0d, expected %0d",
                                    frames_checked, got.field_count, want.field_count));
        if (got.us_first !== want.us_first)
          report_mismatch($sformatf("frame %0d us_first %0d, expected %0d",
                                    frames_checked, got.us_first, want.us_first));
        if (got.us_second !== want.us_second)
          report_mismatch($sformatf("frame %0d us_second %0d, expected %0d",
                                    frames_checked, got.us_second, want.us_second));
        if (got.ir_first !== want.ir_first)
          report_mismatch($sformatf("frame %0d ir_first %0d, expected %0d",
                                    frames_checked, got.ir_first, want.ir_first));
        if (got.ir_second !== want.ir_second)
          report_mismatch($sformatf("frame %0d ir_second %0d, expected %0d",
                                    frames_checked, got.ir_second, want.ir_second));
        if (got.ir_third !== want.ir_third)
          report_mismatch($sformatf("frame %0d ir_third %0d, expected %0d",
                                    frames_checked, got.ir_third, want.ir_third));
      end
      frames_checked++;
    endtask
  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Top level testbench for the bracket frame sensor parser: directed and random byte
// streams with random gaps and stalls. Depends on bfsp_pkg, bfsp_stream_if, frame_tracker_pkg.

module tb_top;
  import bfsp_pkg::*;
  import frame_tracker_pkg::*;

  localparam int RANDOM_FRAME_BYTES = 1500;

  logic clk = 1'b0;
  logic rst;

  bfsp_stream_if #(.payload_t(in_item_t))  rx_if ();
  bfsp_stream_if #(.payload_t(out_item_t)) tx_if ();

  bracket_frame_sensor_parser uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  frame_tracker tracker = new();
  bit rx_steady = 0;
  bit tx_steady = 0;
  int frame_bytes_sent = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) tracker.note_rx_byte(rx_if.data.rx_byte);
      if (tx_if.valid && tx_if.ready) tracker.check_frame(tx_if.data);
    end
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? CH_BLANK : CH_TAB + 8'(r - 1);
  endfunction

  // Appends one byte at the tail of a byte queue.
  function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = rx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      rx_if.data.rx_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.data.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[k]) send_byte(s[k]);
  endtask

  // Holds the sender off until every expected frame has come out.
  task automatic drain_frames();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_frames.size() != 0);
  endtask

  task automatic append_field(ref logic [7:0] q[$]);
    string digits;
    int roll;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) add_byte(q, random_blank());
    roll = $urandom_range(0, 3);
    if (roll == 0) add_byte(q, CH_MINUS);
    else if (roll == 1) add_byte(q, CH_PLUS);
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      digits = "";
    end else if (roll == 1) begin
      digits = $sformatf("%0d", $urandom_range(32760, 99999));
    end else if (roll == 2) begin
      // Far past the saturation point, or padded with leading zeros.
      digits = $urandom_range(0, 1) ? $sformatf("%0d%0d", $urandom_range(1, 999999),
                                                $urandom_range(0, 999999))
                                    : $sformatf("000%0d", $urandom_range(0, 32767));
    end else if (roll < 6) begin
      digits = $sformatf("%0d", $urandom_range(0, 99));
    end else begin
      digits = $sformatf("%0d", $urandom_range(0, 32767));
    end
    foreach (digits[k]) add_byte(q, digits[k]);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) add_byte(q, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    logic [7:0] bytes_q[$];
    int n_fields;
    int roll;
    add_byte(bytes_q, CH_LBRACK);
    roll = $urandom_range(0, 19);
    if (roll < 9) add_byte(bytes_q, CH_KIND_US);
    else if (roll < 18) add_byte(bytes_q, CH_KIND_IR);
    else add_byte(bytes_q, 8'($urandom_range(0, 255)));
    n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) add_byte(bytes_q, CH_COMMA);
      append_field(bytes_q);
    end
    // Now and then the frame is left open and runs into whatever follows.
    if ($urandom_range(0, 15) != 0) add_byte(bytes_q, CH_RBRACK);
    foreach (bytes_q[k]) send_byte(bytes_q[k]);
    frame_bytes_sent += bytes_q.size();
  endtask

  task automatic send_noise();
    int roll;
    repeat ($urandom_range(1, 8)) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) send_byte(CH_RBRACK);
      else if (roll == 1) send_text("[]");
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int stall;
    tx_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
      tx_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = tx_steady ? 0 : pick_gap();
      if (stall > 0) begin
        tx_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    rst <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.data.rx_byte <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Stray bytes, empty frame, unknown kind.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("]x[]");
    send_text("[x12]");
    // Plain frames, an empty field, saturation and lone signs.
    send_text("[u12,-34]");
    send_text("[i+1,2,3]");
    send_text("[u]");
    send_text("[i32767,-32768,99999]");
    send_text("[u-99999,40000]");
    send_text("[u-,+x7]");
    send_text("[i5]");
    send_text("[u1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17]");
    // An opening bracket inside the payload is plain text.
    send_text("[i[5,7x9, 8 9]");
    send_text("[u");
    for (logic [7:0] c = CH_TAB; c <= CH_CR; c++) send_byte(c);
    send_byte(CH_BLANK);
    send_text("42,");
    send_byte(CH_TAB);
    send_text("-7 ]");
    send_text("[i");
    send_byte(8'hFF);
    send_byte(CH_COMMA);
    send_byte(8'h00);
    send_text("3]");
    drain_frames();

    while (frame_bytes_sent < RANDOM_FRAME_BYTES) begin
      if ($urandom_range(0, 24) == 0) rx_steady = !rx_steady;
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_random_frame();
      if ($urandom_range(0, 39) == 0) drain_frames();
    end

    drain_frames();
    repeat (20) @(posedge clk);
    if (tracker.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d frames pending", tracker.pending_frames.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
